### sv/matrix4x4_accumulator_unit_top_assert.svh
// ============================================================================
// Assertion macros for the 4x4 matrix accumulator
// Shared property wrappers: clocked on clk, disabled while arst_n is low.
// ============================================================================
`ifndef MATRIX4X4_ACCUMULATOR_UNIT_TOP_ASSERT_SVH
`define MATRIX4X4_ACCUMULATOR_UNIT_TOP_ASSERT_SVH

// same-cycle implication
`define MXA_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mxa: same-cycle check failed");

// next-cycle implication
`define MXA_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mxa: next-cycle check failed");

`endif

### sv/mxa_pkg.sv
// ============================================================================
// mxa_pkg
// Shared constants, opcodes and control structs of the matrix accumulator.
// ============================================================================
package mxa_pkg;

	localparam int ELEMENT_WIDTH_DEF = 32;
	localparam int DIM               = 4;
	localparam int CELLS             = DIM * DIM;
	localparam int CELL_AW           = $clog2(CELLS);
	localparam int DIM_AW            = $clog2(DIM);
	localparam int MUL_CNT_W         = CELL_AW + DIM_AW;
	localparam int VALUE_W           = 32;
	localparam int OP_W              = 3;
	localparam int S_TDATA_W         = 40;   // row, col, value = 36 bits, byte padded
	localparam int M_TDATA_W         = 40;

	localparam logic [OP_W-1:0] OP_LOAD_W = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_O = 3'd1;
	localparam logic [OP_W-1:0] OP_IDENT  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
	localparam logic [OP_W-1:0] OP_ADD    = 3'd4;
	localparam logic [OP_W-1:0] OP_SUB    = 3'd5;
	localparam logic [OP_W-1:0] OP_READ   = 3'd6;

	// one multiply-accumulate step handed to the MAC
	typedef struct packed {
		logic               vld;
		logic               first;
		logic               last;
		logic [CELL_AW-1:0] dst;
	} mac_ctl_t;

	// finished dot product write into scratch
	typedef struct packed {
		logic               we;
		logic [CELL_AW-1:0] addr;
	} mac_wr_t;

	// diagonal cell of the 4x4 grid
	function automatic logic is_diag(input logic [CELL_AW-1:0] addr);
		return addr[CELL_AW-1:DIM_AW] == addr[DIM_AW-1:0];
	endfunction

endpackage

### sv/mxa_mem.sv
// ============================================================================
// mxa_mem
// 16-entry matrix store: one write port, one read port, registered read data.
// ============================================================================
module mxa_mem #(
	parameter int EW = mxa_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [mxa_pkg::CELL_AW-1:0] waddr,
	input  logic [EW-1:0]              wdata,
	input  logic                       re,
	input  logic [mxa_pkg::CELL_AW-1:0] raddr,
	output logic [EW-1:0]              rdata
);
	import mxa_pkg::*;

	logic [EW-1:0] mem_q [CELLS];
	logic [EW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/mxa_mac.sv
// ============================================================================
// mxa_mac
// Pipelined multiply-accumulate: split partial products, product, running sum.
// ============================================================================
module mxa_mac #(
	parameter int EW = mxa_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mxa_pkg::mac_ctl_t ctl,
	input  logic [EW-1:0]     a,
	input  logic [EW-1:0]     b,
	output mxa_pkg::mac_wr_t  wr,
	output logic [EW-1:0]     res,
	output logic              busy
);
	import mxa_pkg::*;

	// low half H bits, high half LW bits; only the low EW bits of a*b matter
	localparam int H  = (EW + 1) / 2;
	localparam int LW = EW - H;

	mac_ctl_t        ctl_s1, ctl_s2;
	logic [2*H-1:0]  ll_s1;
	logic [LW-1:0]   x1_s1, x2_s1;
	logic [EW-1:0]   prod_s2;
	logic [EW-1:0]   acc_q;
	mac_wr_t         wr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			wr_q   <= '0;
		end else begin
			ctl_s1  <= ctl;
			ctl_s2  <= ctl_s1;
			wr_q.we   <= ctl_s2.vld & ctl_s2.last;
			wr_q.addr <= ctl_s2.dst;
		end
	end

	always_ff @(posedge clk) begin
		ll_s1   <= a[H-1:0] * b[H-1:0];
		x1_s1   <= LW'(a[EW-1:H] * b[LW-1:0]);
		x2_s1   <= LW'(a[LW-1:0] * b[EW-1:H]);
		prod_s2 <= ll_s1[EW-1:0] + {LW'(x1_s1 + x2_s1), {H{1'b0}}};
		if (ctl_s2.vld) begin
			acc_q <= (ctl_s2.first ? '0 : acc_q) + prod_s2;
		end
	end

	assign wr   = wr_q;
	assign res  = acc_q;
	assign busy = ctl_s1.vld | ctl_s2.vld | wr_q.we;

endmodule

### sv/matrix4x4_accumulator_unit_top.sv
// ============================================================================
// matrix4x4_accumulator_unit_top
// 4x4 integer matrix accumulator: working and operand matrices in RAM,
// sequenced multiply, add, subtract and row-major read-out.
// ============================================================================
// Usage:
//   Commands enter on the s_ stream, one beat per command. s_tuser carries
//   the opcode, s_tdata the row, column and value used by the load commands.
//   Read-out results leave on the m_ stream, 16 beats in row-major order,
//   m_tlast on the last element. Other commands give no output beats.
// Command sequences (s_tready low until the command retires):
//   load working / load operand / identity / unused opcode : retired on acceptance
//   add, subtract : 16 RAM reads, one per element, then a drain (ST_WAIT)
//   multiply      : 64 MAC steps through one shared MAC, a MAC pipeline
//                   drain, a scratch copy of 16 reads, then a drain (ST_WAIT)
//   read-out      : 16 reads of the working RAM, one in flight at a time, so
//                   a new read waits until the last word has been registered.
// Reset: both matrices read as identity; per-entry valid flags are cleared,
//   no sweep of the RAMs is needed. An identity command clears the flags
//   of the working matrix.
// Back-pressure: a stalled m_ beat holds in the output register; read-out
//   pauses its RAM reads until the register drains. Once the last read is
//   issued the block takes new commands while that beat still waits.
// ============================================================================
`include "matrix4x4_accumulator_unit_top_assert.svh"

module matrix4x4_accumulator_unit_top #(
	parameter int ELEMENT_WIDTH = mxa_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mxa_pkg::S_TDATA_W-1:0] s_tdata,   // [1:0] row_index, [3:2] col_index,
	                                                 // [35:4] element_value, [39:36] zero
	input  logic [mxa_pkg::OP_W-1:0]      s_tuser,   // [2:0] op
	// read-out stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mxa_pkg::M_TDATA_W-1:0] m_tdata,   // [1:0] out_row, [3:2] out_col,
	                                                 // [35:4] out_value, [39:36] zero
	output logic                          m_tlast    // last
);
	import mxa_pkg::*;

	localparam int EW = ELEMENT_WIDTH;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;  // issue 64 MAC reads
	localparam logic [2:0] ST_MDRN = 3'd2;  // let the MAC pipe empty
	localparam logic [2:0] ST_COPY = 3'd3;  // scratch -> working
	localparam logic [2:0] ST_ADD  = 3'd4;  // add or subtract sweep
	localparam logic [2:0] ST_RD   = 3'd5;  // read-out sweep
	localparam logic [2:0] ST_WAIT = 3'd6;  // last write-back or read-out word lands

	logic [2:0]           state_q, state_nxt;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 sub_q;
	logic [CELLS-1:0]     wv_q, ov_q;   // entry written since reset (working: since reset / identity)

	// command fields
	logic                 s_fire;
	logic [OP_W-1:0]      in_op;
	logic [CELL_AW-1:0]   in_addr;
	logic signed [VALUE_W-1:0] in_val;
	logic [EW-1:0]        ld_val;

	// read issue
	logic                 mul_iss, add_iss, cp_iss, rd_iss, any_iss, last16;
	logic [CELL_AW-1:0]   w_raddr, o_raddr;

	// tags travelling with the RAM read
	logic                 rv_s1;
	logic [2:0]           kind_s1;
	logic                 sub_s1, wvb_s1, ovb_s1, first_s1, last_s1;
	logic [CELL_AW-1:0]   waddr_s1, oaddr_s1, dst_s1;
	logic                 sweep_wb;     // sweep write-back on the working RAM

	// RAM ports
	logic [EW-1:0]        w_rdata, o_rdata, sc_rdata;
	logic [EW-1:0]        w_val, o_val;
	logic                 w_we;
	logic [CELL_AW-1:0]   w_waddr;
	logic [EW-1:0]        w_wdata;
	logic                 o_we;

	// MAC
	mac_ctl_t             mac_ctl;
	mac_wr_t              mac_wr;
	logic [EW-1:0]        mac_res;
	logic                 mac_busy;

	// output register
	logic                 m_vld_q;
	logic [DIM_AW-1:0]    m_row_q, m_col_q;
	logic [VALUE_W-1:0]   m_val_q;
	logic                 m_last_q;

	// ---------------------------------------------------------------- command
	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid & s_tready;
	assign in_op    = s_tuser;
	assign in_addr  = {s_tdata[1:0], s_tdata[3:2]};
	assign in_val   = s_tdata[35:4];
	assign ld_val   = EW'(in_val);   // sign-extend or wrap to element width

	// ---------------------------------------------------------------- issue
	assign mul_iss = (state_q == ST_MUL);
	assign add_iss = (state_q == ST_ADD);
	assign cp_iss  = (state_q == ST_COPY);
	// one read in flight at a time so the output register always has room
	assign rd_iss  = (state_q == ST_RD) && !rv_s1 && (!m_vld_q || m_tready);
	assign any_iss = mul_iss | add_iss | cp_iss | rd_iss;
	assign last16  = (cnt_q[CELL_AW-1:0] == CELL_AW'(CELLS - 1));

	// multiply walks cnt = {i, j, k}: W[i][k] times O[k][j]
	always_comb begin
		if (mul_iss) begin
			w_raddr = {cnt_q[MUL_CNT_W-1 -: DIM_AW], cnt_q[DIM_AW-1:0]};
			o_raddr = {cnt_q[DIM_AW-1:0], cnt_q[CELL_AW-1:DIM_AW]};
		end else begin
			w_raddr = cnt_q[CELL_AW-1:0];
			o_raddr = cnt_q[CELL_AW-1:0];
		end
	end

	// ---------------------------------------------------------------- FSM
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					case (in_op)
						OP_MUL:         state_nxt = ST_MUL;
						OP_ADD, OP_SUB: state_nxt = ST_ADD;
						OP_READ:        state_nxt = ST_RD;
						default:        state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_MUL:  if (cnt_q == '1) state_nxt = ST_MDRN;
			ST_MDRN: if (!rv_s1 && !mac_busy) state_nxt = ST_COPY;
			ST_COPY, ST_ADD: if (last16) state_nxt = ST_WAIT;
			ST_RD:   if (rd_iss && last16) state_nxt = ST_WAIT;
			ST_WAIT: if (!rv_s1) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sub_q   <= 1'b0;
			rv_s1   <= 1'b0;
			kind_s1 <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
			if (any_iss) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == ST_IDLE || state_q == ST_MDRN) begin
				cnt_q <= '0;
			end
			if (s_fire) begin
				sub_q <= (in_op == OP_SUB);
			end
			rv_s1   <= any_iss;
			kind_s1 <= state_q;
		end
	end

	// read tags, payload only
	always_ff @(posedge clk) begin
		sub_s1   <= sub_q;
		waddr_s1 <= w_raddr;
		oaddr_s1 <= o_raddr;
		wvb_s1   <= wv_q[w_raddr];
		ovb_s1   <= ov_q[o_raddr];
		first_s1 <= (cnt_q[DIM_AW-1:0] == '0);
		last_s1  <= (cnt_q[DIM_AW-1:0] == DIM_AW'(DIM - 1));
		dst_s1   <= cnt_q[MUL_CNT_W-1:DIM_AW];
	end

	// never-written entries read as identity
	assign w_val = wvb_s1 ? w_rdata : (is_diag(waddr_s1) ? EW'(1) : '0);
	assign o_val = ovb_s1 ? o_rdata : (is_diag(oaddr_s1) ? EW'(1) : '0);

	// ---------------------------------------------------------------- write-back
	assign sweep_wb = rv_s1 && ((kind_s1 == ST_ADD) || (kind_s1 == ST_COPY));

	always_comb begin
		w_we    = 1'b0;
		w_waddr = waddr_s1;
		w_wdata = sc_rdata;
		if (s_fire && in_op == OP_LOAD_W) begin
			w_we    = 1'b1;
			w_waddr = in_addr;
			w_wdata = ld_val;
		end else if (rv_s1 && kind_s1 == ST_ADD) begin
			w_we    = 1'b1;
			w_wdata = sub_s1 ? (w_val - o_val) : (w_val + o_val);
		end else if (rv_s1 && kind_s1 == ST_COPY) begin
			w_we    = 1'b1;
		end
	end

	assign o_we = s_fire && (in_op == OP_LOAD_O);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_q <= '0;
			ov_q <= '0;
		end else begin
			if (s_fire && in_op == OP_IDENT) begin
				wv_q <= '0;
			end else if (w_we) begin
				wv_q[w_waddr] <= 1'b1;
			end
			if (o_we) begin
				ov_q[in_addr] <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- storage
	mxa_mem #(.EW(EW)) u_wmem (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.re    (mul_iss | add_iss | rd_iss),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	mxa_mem #(.EW(EW)) u_omem (
		.clk   (clk),
		.we    (o_we),
		.waddr (in_addr),
		.wdata (ld_val),
		.re    (mul_iss | add_iss),
		.raddr (o_raddr),
		.rdata (o_rdata)
	);

	mxa_mem #(.EW(EW)) u_smem (
		.clk   (clk),
		.we    (mac_wr.we),
		.waddr (mac_wr.addr),
		.wdata (mac_res),
		.re    (cp_iss),
		.raddr (cnt_q[CELL_AW-1:0]),
		.rdata (sc_rdata)
	);

	// ---------------------------------------------------------------- MAC
	assign mac_ctl.vld   = rv_s1 && (kind_s1 == ST_MUL);
	assign mac_ctl.first = first_s1;
	assign mac_ctl.last  = last_s1;
	assign mac_ctl.dst   = dst_s1;

	mxa_mac #(.EW(EW)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (w_val),
		.b      (o_val),
		.wr     (mac_wr),
		.res    (mac_res),
		.busy   (mac_busy)
	);

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (rv_s1 && kind_s1 == ST_RD) begin
			m_vld_q <= 1'b1;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rv_s1 && kind_s1 == ST_RD) begin
			m_row_q  <= waddr_s1[CELL_AW-1:DIM_AW];
			m_col_q  <= waddr_s1[DIM_AW-1:0];
			m_val_q  <= VALUE_W'($signed(w_val));
			m_last_q <= (waddr_s1 == CELL_AW'(CELLS - 1));
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {(M_TDATA_W - VALUE_W - 2 * DIM_AW)'(0), m_val_q, m_col_q, m_row_q};
	assign m_tlast  = m_last_q;

	// ---------------------------------------------------------------- checks
	// a read-out word only lands in an empty output register
	`MXA_AST_IMP(a_out_slot_free, rv_s1 && (kind_s1 == ST_RD), !m_vld_q)
	// a load never meets a sweep write-back on the working RAM port
	`MXA_AST_IMP(a_wport_single, s_fire && (in_op == OP_LOAD_W), !sweep_wb)
	// scratch copy starts only after every dot product is written
	`MXA_AST_IMP(a_copy_after_mac, state_q == ST_COPY, !mac_busy)
	// identity leaves every working entry reading as reset
	`MXA_AST_NXT(a_ident_clears, s_fire && (in_op == OP_IDENT), wv_q == '0)

endmodule
